// File: hw/rtl/bpcw_pkg.sv
// bpcw_pkg: shared types, constants and bit functions for the crc/whitening core
// used by the cfg interface, front, back and core rtl files, depends on nothing
`default_nettype none
package bpcw_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [23:0] CRC_POLY = 24'h00065B;
  localparam logic [7:0]  WHITEN_TAP = 8'h11;
  localparam logic [5:0]  CHANNEL_RESET = 6'd37;
  localparam logic [23:0] CRC_INIT_RESET = 24'h555555;
  localparam logic [7:0]  SEED_FORCE = 8'h02;

  typedef logic [Q_PTR_W-1:0] q_ptr_t;
  typedef logic [Q_CNT_W-1:0] q_cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL  = 2'd0,
    REG_CRC_INIT = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_HI,
    TAIL_MID,
    TAIL_LO
  } tail_t;

  typedef struct packed {
    logic [7:0] pdu_byte;
    logic       last_byte;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_front_t;

  typedef struct packed {
    logic [7:0] state;
    logic [7:0] data;
  } whiten_res_t;

  function automatic logic [7:0] rev8(input logic [7:0] a);
    logic [7:0] v;
    for (int i = 0; i < 8; i++) begin
      v[7-i] = a[i];
    end
    return v;
  endfunction

  function automatic logic [7:0] seed_of(input logic [5:0] ch);
    return rev8({2'b00, ch}) | SEED_FORCE;
  endfunction

  function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] d);
    logic [23:0] c;
    logic        top;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      top = c[23];
      c = {c[22:0], 1'b0};
      if (top != d[i]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic whiten_res_t whiten_byte(input logic [7:0] w, input logic [7:0] d);
    whiten_res_t r;
    logic [7:0]  s;
    logic [7:0]  o;
    s = w;
    o = d;
    for (int i = 0; i < 8; i++) begin
      if (s[7]) begin
        s = s ^ WHITEN_TAP;
        o[i] = ~o[i];
      end
      s = {s[6:0], 1'b0};
    end
    r.state = s;
    r.data = o;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bpcw_in_if.sv
// bpcw_in_if: pdu byte request channel
// depends on nothing
`default_nettype none
interface bpcw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pdu_byte;
  logic       last_byte;

  modport source (output valid, output pdu_byte, output last_byte, input ready);
  modport sink (input valid, input pdu_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bpcw_out_if.sv
// bpcw_out_if: transmit byte request channel
// depends on nothing
`default_nettype none
interface bpcw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_crc;
  logic       last_out;

  modport source (output valid, output out_byte, output is_crc, output last_out, input ready);
  modport sink (input valid, input out_byte, input is_crc, input last_out, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bpcw_cfg_if.sv
// bpcw_cfg_if: register write channel
// depends on bpcw_pkg for index and data widths
`default_nettype none
interface bpcw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bpcw_pkg::CFG_IDX_W-1:0]  index;
  logic [bpcw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/bpcw_front.sv
// bpcw_front: accepts pdu byte requests into a two-entry queue
// depends on bpcw_pkg and bpcw_in_if
`default_nettype none
module bpcw_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  bpcw_in_if.sink             in_ch,
  output bpcw_pkg::q_front_t  q,
  input  wire logic           q_pop
);

  bpcw_pkg::q_item_t mem_r [bpcw_pkg::QUEUE_DEPTH];
  bpcw_pkg::q_ptr_t  wr_ptr_r, wr_ptr_nxt;
  bpcw_pkg::q_ptr_t  rd_ptr_r, rd_ptr_nxt;
  bpcw_pkg::q_cnt_t  count_r, count_nxt;
  logic              push;
  logic              pop;

  assign in_ch.ready = (count_r != bpcw_pkg::q_cnt_t'(bpcw_pkg::QUEUE_DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign pop = q_pop && (count_r != '0);

  assign q.valid = (count_r != '0);
  assign q.item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + bpcw_pkg::q_ptr_t'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + bpcw_pkg::q_ptr_t'(1) : rd_ptr_r;
    count_nxt = count_r + bpcw_pkg::q_cnt_t'(push) - bpcw_pkg::q_cnt_t'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{pdu_byte: in_ch.pdu_byte, last_byte: in_ch.last_byte};
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bpcw_back.sv
// bpcw_back: crc-24 and whitening engine with crc tail sequencer and output register
// depends on bpcw_pkg, bpcw_cfg_if and bpcw_out_if
`default_nettype none
module bpcw_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  bpcw_cfg_if.sink                  cfg,
  input  wire bpcw_pkg::q_front_t   q,
  output logic                      q_pop,
  bpcw_out_if.source                out_ch
);

  logic [5:0]          channel_r, channel_nxt;
  logic [23:0]         crc_init_r, crc_init_nxt;
  logic [23:0]         crc_r, crc_nxt;
  logic [7:0]          wht_r, wht_nxt;
  bpcw_pkg::tail_t     tail_r, tail_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                is_crc_r, is_crc_nxt;
  logic                last_out_r, last_out_nxt;
  logic                load;
  logic                cfg_wr;
  logic [7:0]          crc_sel;
  bpcw_pkg::whiten_res_t wres;

  assign cfg.ready = 1'b1;
  assign cfg_wr = cfg.valid;
  assign load = !out_valid_r || out_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.is_crc = is_crc_r;
  assign out_ch.last_out = last_out_r;

  always_comb begin
    case (tail_r)
      bpcw_pkg::TAIL_HI:  crc_sel = crc_r[23:16];
      bpcw_pkg::TAIL_MID: crc_sel = crc_r[15:8];
      default:            crc_sel = crc_r[7:0];
    endcase
  end

  always_comb begin
    channel_nxt = channel_r;
    crc_init_nxt = crc_init_r;
    crc_nxt = crc_r;
    wht_nxt = wht_r;
    tail_nxt = tail_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt = out_byte_r;
    is_crc_nxt = is_crc_r;
    last_out_nxt = last_out_r;
    q_pop = 1'b0;
    wres = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (load) begin
      case (tail_r)
        bpcw_pkg::TAIL_NONE: begin
          if (q.valid) begin
            q_pop = 1'b1;
            crc_nxt = bpcw_pkg::crc_byte(crc_r, q.item.pdu_byte);
            wres = bpcw_pkg::whiten_byte(wht_r, q.item.pdu_byte);
            wht_nxt = wres.state;
            out_valid_nxt = 1'b1;
            out_byte_nxt = bpcw_pkg::rev8(wres.data);
            is_crc_nxt = 1'b0;
            last_out_nxt = 1'b0;
            tail_nxt = q.item.last_byte ? bpcw_pkg::TAIL_HI : bpcw_pkg::TAIL_NONE;
          end
        end
        default: begin
          wres = bpcw_pkg::whiten_byte(wht_r, bpcw_pkg::rev8(crc_sel));
          wht_nxt = wres.state;
          out_valid_nxt = 1'b1;
          out_byte_nxt = bpcw_pkg::rev8(wres.data);
          is_crc_nxt = 1'b1;
          last_out_nxt = (tail_r == bpcw_pkg::TAIL_LO);
          case (tail_r)
            bpcw_pkg::TAIL_HI:  tail_nxt = bpcw_pkg::TAIL_MID;
            bpcw_pkg::TAIL_MID: tail_nxt = bpcw_pkg::TAIL_LO;
            default: begin
              tail_nxt = bpcw_pkg::TAIL_NONE;
              crc_nxt = crc_init_r;
              wht_nxt = bpcw_pkg::seed_of(channel_r);
            end
          endcase
        end
      endcase
    end

    if (cfg_wr) begin
      case (cfg.index)
        bpcw_pkg::REG_CHANNEL: begin
          channel_nxt = cfg.data[5:0];
          wht_nxt = bpcw_pkg::seed_of(cfg.data[5:0]);
        end
        bpcw_pkg::REG_CRC_INIT: begin
          crc_init_nxt = cfg.data[23:0];
          crc_nxt = cfg.data[23:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r <= bpcw_pkg::CHANNEL_RESET;
      crc_init_r <= bpcw_pkg::CRC_INIT_RESET;
      crc_r <= bpcw_pkg::CRC_INIT_RESET;
      wht_r <= bpcw_pkg::seed_of(bpcw_pkg::CHANNEL_RESET);
      tail_r <= bpcw_pkg::TAIL_NONE;
      out_valid_r <= 1'b0;
    end else begin
      channel_r <= channel_nxt;
      crc_init_r <= crc_init_nxt;
      crc_r <= crc_nxt;
      wht_r <= wht_nxt;
      tail_r <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    is_crc_r <= is_crc_nxt;
    last_out_r <= last_out_nxt;
  end

endmodule
`default_nettype wire

// File: hw/rtl/ble_packet_crc_whitener_core.sv
// ble_packet_crc_whitener_core: ble crc-24 append and whitening, one pdu byte per request
// a pdu byte passes through the queue register and then the output register
// throughput: one byte per cycle while the output is not stalled; a last byte is followed
//   by three crc tail bytes, during which the queue fills up to two entries and then stalls
// reset: synchronous active low; channel 37, crc init 0x555555, queue and output empty
// depends on bpcw_pkg, bpcw_in_if, bpcw_out_if, bpcw_cfg_if, bpcw_front, bpcw_back
`default_nettype none
module ble_packet_crc_whitener_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bpcw_in_if.sink    in_ch,
  bpcw_out_if.source out_ch,
  bpcw_cfg_if.sink   cfg_ch
);

  bpcw_pkg::q_front_t q;
  logic               q_pop;

  bpcw_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q     (q),
    .q_pop (q_pop)
  );

  bpcw_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_ch),
    .q      (q),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// File: hw/rtl/bpcw_checker.sv
// bpcw_checker: port-level checks of the crc tail framing and output register
// bound to ble_packet_crc_whitener_core, depends on nothing else
`default_nettype none
module bpcw_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       is_crc,
  input wire logic       last_out
);

  logic [1:0] crc_run_r;
  logic       out_acc;

  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_run_r <= 2'd0;
    end else if (out_acc) begin
      if (!is_crc || last_out) begin
        crc_run_r <= 2'd0;
      end else if (crc_run_r != 2'd3) begin
        crc_run_r <= crc_run_r + 2'd1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_crc)
      && $stable(last_out))
    else $error("output changed while stalled");

  a_last_after_two_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && last_out |-> is_crc && crc_run_r == 2'd2)
    else $error("last crc byte not preceded by two crc bytes");

  a_crc_not_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && is_crc && !last_out |-> crc_run_r < 2'd2)
    else $error("crc tail longer than three bytes");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind ble_packet_crc_whitener_core bpcw_checker u_bpcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .is_crc    (out_ch.is_crc),
  .last_out  (out_ch.last_out)
);
`default_nettype wire

// File: verif/tb_ble_packet_crc_whitener_core.sv
// tb_ble_packet_crc_whitener_core: self-checking bench for the ble crc-24 and whitening core
// drives pdu byte requests and register writes, predicts every transmit byte and compares
// depends on bpcw_pkg, bpcw_in_if, bpcw_out_if, bpcw_cfg_if and the core
module tb_ble_packet_crc_whitener_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bpcw_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [bpcw_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int RANDOM_ITEMS = 350;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [7:0] data;
    logic       is_crc;
    logic       last;
  } tx_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       pdu_valid = 1'b0;
  logic [7:0] pdu_data = 8'h00;
  logic       pdu_last = 1'b0;
  logic       tx_ready = 1'b0;

  bpcw_in_if  pdu_bus ();
  bpcw_out_if tx_bus ();
  bpcw_cfg_if reg_bus ();

  assign pdu_bus.valid = pdu_valid;
  assign pdu_bus.pdu_byte = pdu_data;
  assign pdu_bus.last_byte = pdu_last;
  assign tx_bus.ready = tx_ready;

  ble_packet_crc_whitener_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pdu_bus),
    .out_ch (tx_bus),
    .cfg_ch (reg_bus)
  );

  always #5 clk = ~clk;

  bpcw_pkg::q_item_t pdu_pend_q[$];
  tx_byte_t          tx_want_q[$];
  bpcw_pkg::q_item_t pdu_next;

  logic [5:0]  chan_r;
  logic [23:0] crc_init_r;
  logic [23:0] crc_st;
  logic [7:0]  lfsr_st;
  logic        fb;
  logic [7:0]  tail;
  tx_byte_t    want;
  tx_byte_t    head;

  logic pdu_fire = 1'b0;
  logic tx_fire = 1'b0;
  logic pdu_idle_on = 1'b0;
  logic tx_idle_on = 1'b0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_cnt = 0;
  int   pdu_wait = 0;
  int   tx_wait = 0;
  int   idle_cycles = 0;
  int   err_count = 0;

  function automatic logic [7:0] flip8(input logic [7:0] a);
    return {a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7]};
  endfunction

  function automatic logic [7:0] seed_for(input logic [5:0] ch);
    return flip8({2'b00, ch}) | bpcw_pkg::SEED_FORCE;
  endfunction

  // advances the whitening lfsr by eight steps and returns the masked byte
  function automatic logic [7:0] whiten_step(input logic [7:0] d);
    logic [7:0] r;
    r = d;
    for (int k = 0; k < 8; k++) begin
      if (lfsr_st[7]) begin
        lfsr_st = lfsr_st ^ bpcw_pkg::WHITEN_TAP;
        r = r ^ (8'h01 << k);
      end
      lfsr_st = {lfsr_st[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic int draw_wait(input logic idle_on);
    return idle_on ? $urandom_range(0, 16) : 0;
  endfunction

  // pdu request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      pdu_valid <= 1'b0;
    end else if (!pdu_valid || pdu_fire) begin
      if (pdu_wait != 0) begin
        pdu_valid <= 1'b0;
        pdu_wait <= pdu_wait - 1;
      end else if (pdu_pend_q.size() != 0) begin
        pdu_next = pdu_pend_q.pop_front();
        pdu_valid <= 1'b1;
        pdu_data <= pdu_next.pdu_byte;
        pdu_last <= pdu_next.last_byte;
        pdu_wait <= draw_wait(pdu_idle_on);
      end else begin
        pdu_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req != hold_ack) begin
      hold_cnt <= HOLD_CYCLES;
      hold_ack <= hold_req;
    end
  end

  // transmit side ready
  always @(negedge clk) begin
    if (!rst_n || hold_cnt != 0) begin
      tx_ready <= 1'b0;
    end else if (tx_wait != 0) begin
      tx_ready <= 1'b0;
      tx_wait <= tx_wait - 1;
    end else if (tx_fire) begin
      tx_wait <= draw_wait(tx_idle_on);
      tx_ready <= (tx_idle_on == 1'b0);
    end else begin
      tx_ready <= 1'b1;
    end
  end

  // prediction and checking
  always @(posedge clk) begin
    if (!rst_n) begin
      pdu_fire <= 1'b0;
      tx_fire <= 1'b0;
      chan_r = bpcw_pkg::CHANNEL_RESET;
      crc_init_r = bpcw_pkg::CRC_INIT_RESET;
      crc_st = bpcw_pkg::CRC_INIT_RESET;
      lfsr_st = seed_for(bpcw_pkg::CHANNEL_RESET);
    end else begin
      pdu_fire <= pdu_bus.valid && pdu_bus.ready;
      tx_fire <= tx_bus.valid && tx_bus.ready;
      if (reg_bus.valid && reg_bus.ready) begin
        if (reg_bus.index == bpcw_pkg::REG_CHANNEL) begin
          chan_r = reg_bus.data[5:0];
          lfsr_st = seed_for(chan_r);
        end else if (reg_bus.index == bpcw_pkg::REG_CRC_INIT) begin
          crc_init_r = reg_bus.data;
          crc_st = reg_bus.data;
        end
      end
      if (pdu_bus.valid && pdu_bus.ready) begin
        for (int k = 0; k < 8; k++) begin
          fb = crc_st[23] ^ pdu_bus.pdu_byte[k];
          crc_st = {crc_st[22:0], 1'b0} ^ (fb ? bpcw_pkg::CRC_POLY : 24'h000000);
        end
        want.data = flip8(whiten_step(pdu_bus.pdu_byte));
        want.is_crc = 1'b0;
        want.last = 1'b0;
        tx_want_q.push_back(want);
        if (pdu_bus.last_byte) begin
          for (int j = 0; j < 3; j++) begin
            tail = crc_st[23 - 8 * j -: 8];
            want.data = flip8(whiten_step(flip8(tail)));
            want.is_crc = 1'b1;
            want.last = (j == 2);
            tx_want_q.push_back(want);
          end
          crc_st = crc_init_r;
          lfsr_st = seed_for(chan_r);
        end
      end
      if (tx_bus.valid && tx_bus.ready) begin
        if (tx_want_q.size() == 0) begin
          $error("out_byte with nothing pending: %h", tx_bus.out_byte);
          err_count++;
        end else begin
          head = tx_want_q.pop_front();
          if (tx_bus.out_byte !== head.data) begin
            $error("out_byte expected %h got %h", head.data, tx_bus.out_byte);
            err_count++;
          end
          if (tx_bus.is_crc !== head.is_crc) begin
            $error("is_crc expected %b got %b", head.is_crc, tx_bus.is_crc);
            err_count++;
          end
          if (tx_bus.last_out !== head.last) begin
            $error("last_out expected %b got %b", head.last, tx_bus.last_out);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (pdu_bus.valid && pdu_bus.ready) || (tx_bus.valid && tx_bus.ready)
        || (reg_bus.valid && reg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [bpcw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bpcw_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    reg_bus.valid = 1'b1;
    reg_bus.index = idx;
    reg_bus.data = val;
    @(posedge clk);
    while (!reg_bus.ready) @(posedge clk);
    @(negedge clk);
    reg_bus.valid = 1'b0;
  endtask

  task automatic add_byte(input logic [7:0] b, input logic l);
    bpcw_pkg::q_item_t it;
    it.pdu_byte = b;
    it.last_byte = l;
    pdu_pend_q.push_back(it);
  endtask

  task automatic add_packet(input int len, input logic close);
    for (int i = 0; i < len; i++) begin
      add_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
    end
  endtask

  task automatic settle();
    while (pdu_pend_q.size() != 0 || pdu_valid || tx_want_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [5:0] pick_channel();
    return ($urandom_range(0, 7) == 0) ? 6'($urandom_range(40, 63)) : 6'($urandom_range(0, 39));
  endfunction

  initial begin
    int queued;
    int n;
    int plen;
    int phase;
    reg_bus.valid = 1'b0;
    reg_bus.index = bpcw_pkg::REG_CHANNEL;
    reg_bus.data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: single-byte packets and an advertising style header
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h42, 1'b0);
    add_byte(8'h03, 1'b0);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(8'h80, 1'b1);
    settle();

    write_reg(bpcw_pkg::REG_CHANNEL, 24'd0);
    write_reg(bpcw_pkg::REG_CRC_INIT, 24'h000000);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    settle();

    write_reg(bpcw_pkg::REG_CHANNEL, 24'd39);
    write_reg(bpcw_pkg::REG_CRC_INIT, 24'hFFFFFF);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'hFE, 1'b1);
    settle();

    // channel beyond 39 and writes to unused indexes
    write_reg(bpcw_pkg::REG_CHANNEL, 24'd63);
    write_reg(REG_SPARE_2, 24'hFFFFFF);
    write_reg(REG_SPARE_3, 24'hFFFFFF);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h80, 1'b1);
    settle();

    // register writes in the middle of a packet
    write_reg(bpcw_pkg::REG_CHANNEL, 24'd40);
    write_reg(bpcw_pkg::REG_CRC_INIT, bpcw_pkg::CRC_INIT_RESET);
    add_byte(8'h12, 1'b0);
    add_byte(8'h34, 1'b0);
    settle();
    write_reg(bpcw_pkg::REG_CHANNEL, 24'(bpcw_pkg::CHANNEL_RESET));
    write_reg(bpcw_pkg::REG_CRC_INIT, 24'hABCDEF);
    add_byte(8'h56, 1'b0);
    add_byte(8'h78, 1'b1);
    settle();

    queued = 0;
    phase = 0;
    while (queued < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: begin
          write_reg(bpcw_pkg::REG_CHANNEL,
                    (24'($urandom()) & 24'hFFFFC0) | 24'(pick_channel()));
          write_reg(bpcw_pkg::REG_CRC_INIT, 24'($urandom()));
        end
        1: write_reg(bpcw_pkg::REG_CHANNEL, 24'(pick_channel()));
        2: write_reg(bpcw_pkg::REG_CRC_INIT, 24'($urandom()));
        3: begin
          write_reg(bpcw_pkg::REG_CHANNEL, $urandom_range(0, 1) ? 24'd39 : 24'd0);
          write_reg(bpcw_pkg::REG_CRC_INIT, $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000);
        end
        4: write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 24'($urandom()));
        default: ;
      endcase
      pdu_idle_on = ($urandom_range(0, 2) != 0);
      tx_idle_on = ($urandom_range(0, 2) != 0);
      n = $urandom_range(25, 50);
      queued += n;
      while (n > 0) begin
        plen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if (plen >= n) begin
          add_packet(n, $urandom_range(0, 3) != 0);
          n = 0;
        end else begin
          add_packet(plen, 1'b1);
          n -= plen;
        end
      end
      if (phase == 2) begin
        hold_req = ~hold_req;
      end
      phase++;
      settle();
    end

    settle();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
